// File: sv/esu8_pkg.sv
// Package with shared types, character codes and the UTF-8 encoder of the escape decoder.
`default_nettype none
package esu8_pkg;

	// Width of the digit run accumulator.
	localparam int VALUE_WIDTH = 32;

	// Number of bytes one input byte can cause at most.
	localparam int MAX_OUT = 5;
	localparam int LEN_W   = 3;

	// Character codes.
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_SEVEN     = 8'h37;
	localparam logic [7:0] CH_NINE      = 8'h39;
	localparam logic [7:0] CH_LOWER_A   = 8'h61;
	localparam logic [7:0] CH_LOWER_B   = 8'h62;
	localparam logic [7:0] CH_LOWER_F   = 8'h66;
	localparam logic [7:0] CH_LOWER_N   = 8'h6E;
	localparam logic [7:0] CH_LOWER_R   = 8'h72;
	localparam logic [7:0] CH_LOWER_T   = 8'h74;
	localparam logic [7:0] CH_LOWER_U   = 8'h75;
	localparam logic [7:0] CH_LOWER_V   = 8'h76;
	localparam logic [7:0] CH_LOWER_X   = 8'h78;
	localparam logic [7:0] CH_UPPER_A   = 8'h41;
	localparam logic [7:0] CH_UPPER_F   = 8'h46;
	localparam logic [7:0] CH_UPPER_U   = 8'h55;

	// Control codes of the single-letter escapes.
	localparam logic [7:0] CC_BEL = 8'h07;
	localparam logic [7:0] CC_BS  = 8'h08;
	localparam logic [7:0] CC_FF  = 8'h0C;
	localparam logic [7:0] CC_LF  = 8'h0A;
	localparam logic [7:0] CC_CR  = 8'h0D;
	localparam logic [7:0] CC_HT  = 8'h09;
	localparam logic [7:0] CC_VT  = 8'h0B;

	// Replacement character U+FFFD in UTF-8.
	localparam logic [7:0] REPL_0 = 8'hEF;
	localparam logic [7:0] REPL_1 = 8'hBF;
	localparam logic [7:0] REPL_2 = 8'hBD;

	typedef enum logic [1:0] {
		MODE_PLAIN = 2'd0,
		MODE_ESC   = 2'd1,
		MODE_HEX   = 2'd2,
		MODE_OCT   = 2'd3
	} mode_t;

	// Decoder state carried from one byte to the next.
	typedef struct packed {
		mode_t                  mode;
		logic [VALUE_WIDTH-1:0] acc;
		logic                   seen;
		logic                   ovf;
		logic [7:0]             letter;
	} dec_state_t;

	// All result bytes caused by one input byte, first byte at index 0.
	typedef struct packed {
		logic [MAX_OUT-1:0][7:0] bytes;
		logic [MAX_OUT-1:0]      big;
		logic [LEN_W-1:0]        len;
		logic                    done;
	} out_bundle_t;

	// One encoded code point.
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [LEN_W-1:0] len;
		logic             big;
	} enc_t;

	// Encodes a run value as UTF-8; an overflowed run gives a lone backslash.
	function automatic enc_t utf8_encode(input logic [31:0] v, input logic ovf);
		enc_t e;
		e       = '0;
		if (ovf) begin
			e.bytes[0] = CH_BACKSLASH;
			e.len      = 3'd1;
		end else if (v[31:21] != '0) begin
			e.bytes[0] = REPL_0;
			e.bytes[1] = REPL_1;
			e.bytes[2] = REPL_2;
			e.len      = 3'd3;
			e.big      = 1'b1;
		end else if (v[31:7] == '0) begin
			e.bytes[0] = {1'b0, v[6:0]};
			e.len      = 3'd1;
		end else if (v[31:11] == '0) begin
			e.bytes[0] = {3'b110, v[10:6]};
			e.bytes[1] = {2'b10, v[5:0]};
			e.len      = 3'd2;
		end else if (v[31:16] == '0) begin
			e.bytes[0] = {4'b1110, v[15:12]};
			e.bytes[1] = {2'b10, v[11:6]};
			e.bytes[2] = {2'b10, v[5:0]};
			e.len      = 3'd3;
		end else begin
			e.bytes[0] = {5'b11110, v[20:18]};
			e.bytes[1] = {2'b10, v[17:12]};
			e.bytes[2] = {2'b10, v[11:6]};
			e.bytes[3] = {2'b10, v[5:0]};
			e.len      = 3'd4;
		end
		return e;
	endfunction

endpackage
`default_nettype wire

// File: sv/esu8_if.sv
// Stream interfaces for raw input bytes and decoded UTF-8 bytes.
`default_nettype none
interface esu8_raw_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_text;

	modport source (output valid, in_byte, end_of_text, input ready);
	modport sink (input valid, in_byte, end_of_text, output ready);
endinterface

interface esu8_utf8_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       text_done;
	logic       code_too_large;

	modport source (output valid, out_byte, run_last, text_done, code_too_large, input ready);
	modport sink (input valid, out_byte, run_last, text_done, code_too_large, output ready);
endinterface
`default_nettype wire

// File: sv/escape_sequence_to_utf8_decoder_core.sv
// Top level of the C escape sequence to UTF-8 decoder.
//
// The raw channel takes one byte of text per transaction, with end_of_text
// marking the last byte of a string. The utf8 channel gives the decoded
// bytes, one per transaction; run_last marks the last byte caused by an
// input byte, text_done the final byte of a string, and code_too_large the
// three replacement bytes that stand for a value above 0x1FFFFF.
// An accepted byte is decoded in the cycle of its transaction and its
// results appear in the output buffer from the next cycle. An input byte
// causes 0 to 5 results and holds the buffer until the last of them
// leaves; a new byte is taken in the cycle the last of them leaves, so
// while the receiver is ready plain text flows at one byte per cycle and
// only multi-byte escapes hold the input back. A byte that causes nothing
// (a backslash or a digit inside a run) leaves the buffer empty.
// Reset puts the decoder in plain text mode and empties the output buffer.
// When the receiver stalls, the buffered bytes hold and the input is not
// taken until the buffer can be refilled.
`default_nettype none
module escape_sequence_to_utf8_decoder_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	esu8_raw_if.sink           raw,
	esu8_utf8_if.source        utf8
);

	esu8_pkg::dec_state_t  state_q;
	esu8_pkg::dec_state_t  state_nxt;
	esu8_pkg::out_bundle_t bundle;

	logic [esu8_pkg::MAX_OUT-1:0][7:0] bytes_s1;
	logic [esu8_pkg::MAX_OUT-1:0]      big_s1;
	logic                              done_s1;
	logic [esu8_pkg::LEN_W-1:0]        rem_q;

	logic last_out;
	logic in_fire;
	logic out_fire;

	esu8_step u_step (
		.cur         (state_q),
		.in_byte     (raw.in_byte),
		.end_of_text (raw.end_of_text),
		.nxt         (state_nxt),
		.bundle      (bundle)
	);

	// Handshakes: refill the buffer when it is empty or its last byte leaves now.
	always_comb begin
		last_out  = (rem_q == esu8_pkg::LEN_W'(1));
		utf8.valid = (rem_q != '0);
		out_fire  = utf8.valid && utf8.ready;
		raw.ready = (rem_q == '0) || (last_out && utf8.ready);
		in_fire   = raw.valid && raw.ready;
	end

	// Output fields come from the head of the buffer.
	always_comb begin
		utf8.out_byte       = bytes_s1[0];
		utf8.code_too_large = big_s1[0];
		utf8.run_last       = last_out;
		utf8.text_done      = last_out && done_s1;
	end

	// Decoder state and buffer fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{mode: esu8_pkg::MODE_PLAIN, default: '0};
			rem_q   <= '0;
		end else begin
			if (in_fire) begin
				state_q <= state_nxt;
				rem_q   <= bundle.len;
			end else if (out_fire) begin
				rem_q   <= rem_q - esu8_pkg::LEN_W'(1);
			end
		end
	end

	// Buffer payload: load on a new transaction, shift as bytes leave.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			bytes_s1 <= bundle.bytes;
			big_s1   <= bundle.big;
			done_s1  <= bundle.done;
		end else if (out_fire) begin
			bytes_s1 <= {8'h00, bytes_s1[esu8_pkg::MAX_OUT-1:1]};
			big_s1   <= {1'b0, big_s1[esu8_pkg::MAX_OUT-1:1]};
		end
	end

endmodule
`default_nettype wire

// File: sv/esu8_step.sv
// Combinational decode of one input byte: next state and the bytes it causes.
`default_nettype none
module esu8_step (
	input  wire esu8_pkg::dec_state_t  cur,
	input  wire logic [7:0]            in_byte,
	input  wire logic                  end_of_text,
	output esu8_pkg::dec_state_t       nxt,
	output esu8_pkg::out_bundle_t      bundle
);

	localparam int VW = esu8_pkg::VALUE_WIDTH;

	logic          is_hex_digit;
	logic          is_oct_digit;
	logic [3:0]    digit;
	logic          hex_mode;
	logic [VW-1:0] acc_add;
	logic          ovf_add;
	logic          run_en;
	logic [31:0]   run_v;
	logic          run_ovf;
	logic          tail_en;
	logic [7:0]    tail_b;
	esu8_pkg::enc_t enc;
	logic [esu8_pkg::LEN_W-1:0] run_len;

	// Digit classification of the incoming byte.
	always_comb begin
		is_oct_digit = (in_byte >= esu8_pkg::CH_ZERO) && (in_byte <= esu8_pkg::CH_SEVEN);
		is_hex_digit = 1'b0;
		digit        = '0;
		if ((in_byte >= esu8_pkg::CH_ZERO) && (in_byte <= esu8_pkg::CH_NINE)) begin
			is_hex_digit = 1'b1;
			digit        = 4'(in_byte - esu8_pkg::CH_ZERO);
		end else if ((in_byte >= esu8_pkg::CH_LOWER_A) && (in_byte <= esu8_pkg::CH_LOWER_F)) begin
			is_hex_digit = 1'b1;
			digit        = 4'(in_byte - esu8_pkg::CH_LOWER_A + 8'd10);
		end else if ((in_byte >= esu8_pkg::CH_UPPER_A) && (in_byte <= esu8_pkg::CH_UPPER_F)) begin
			is_hex_digit = 1'b1;
			digit        = 4'(in_byte - esu8_pkg::CH_UPPER_A + 8'd10);
		end
	end

	// Accumulator update for one more digit; on overflow the value holds.
	always_comb begin
		hex_mode = (cur.mode == esu8_pkg::MODE_HEX);
		if (hex_mode) begin
			ovf_add = cur.ovf || (cur.acc[VW-1 -: 4] != '0);
			acc_add = (cur.acc[VW-1 -: 4] != '0) ? cur.acc : {cur.acc[VW-5:0], digit};
		end else begin
			ovf_add = cur.ovf || (cur.acc[VW-1 -: 3] != '0);
			acc_add = (cur.acc[VW-1 -: 3] != '0) ? cur.acc : {cur.acc[VW-4:0], digit[2:0]};
		end
	end

	// Mode handling: decide the code to encode, the pass-through byte and the next state.
	always_comb begin
		nxt     = cur;
		run_en  = 1'b0;
		run_v   = '0;
		run_ovf = 1'b0;
		tail_en = 1'b0;
		tail_b  = in_byte;
		case (cur.mode)
			esu8_pkg::MODE_PLAIN: begin
				if ((in_byte == esu8_pkg::CH_BACKSLASH) && !end_of_text) begin
					nxt.mode = esu8_pkg::MODE_ESC;
				end else begin
					tail_en = 1'b1;
				end
			end
			esu8_pkg::MODE_ESC: begin
				nxt        = '0;
				nxt.mode   = esu8_pkg::MODE_PLAIN;
				run_en     = 1'b1;
				case (in_byte)
					esu8_pkg::CH_LOWER_A: run_v = {24'd0, esu8_pkg::CC_BEL};
					esu8_pkg::CH_LOWER_B: run_v = {24'd0, esu8_pkg::CC_BS};
					esu8_pkg::CH_LOWER_F: run_v = {24'd0, esu8_pkg::CC_FF};
					esu8_pkg::CH_LOWER_N: run_v = {24'd0, esu8_pkg::CC_LF};
					esu8_pkg::CH_LOWER_R: run_v = {24'd0, esu8_pkg::CC_CR};
					esu8_pkg::CH_LOWER_T: run_v = {24'd0, esu8_pkg::CC_HT};
					esu8_pkg::CH_LOWER_V: run_v = {24'd0, esu8_pkg::CC_VT};
					esu8_pkg::CH_LOWER_X, esu8_pkg::CH_LOWER_U, esu8_pkg::CH_UPPER_U: begin
						// A hex run starts; at the end of the text the letter stands alone.
						run_v = {24'd0, in_byte};
						if (!end_of_text) begin
							run_en     = 1'b0;
							nxt.mode   = esu8_pkg::MODE_HEX;
							nxt.letter = in_byte;
						end
					end
					default: begin
						if (is_oct_digit) begin
							// An octal run starts with this digit as its value.
							run_v = {29'd0, digit[2:0]};
							if (!end_of_text) begin
								run_en     = 1'b0;
								nxt.mode   = esu8_pkg::MODE_OCT;
								nxt.acc    = VW'(digit[2:0]);
								nxt.seen   = 1'b1;
								nxt.letter = in_byte;
							end
						end else begin
							run_v = {24'd0, in_byte};
						end
					end
				endcase
			end
			default: begin
				// Inside a hex or octal run.
				if (hex_mode ? is_hex_digit : is_oct_digit) begin
					nxt.acc  = acc_add;
					nxt.ovf  = ovf_add;
					nxt.seen = 1'b1;
					if (end_of_text) begin
						run_en  = 1'b1;
						run_v   = 32'(acc_add);
						run_ovf = ovf_add;
					end
				end else begin
					// The run ends here; the byte is then handled as in plain text, so a backslash starts a new escape.
					run_en  = 1'b1;
					run_v   = cur.seen ? 32'(cur.acc) : {24'd0, cur.letter};
					run_ovf = cur.ovf;
					nxt     = '0;
					nxt.mode = esu8_pkg::MODE_PLAIN;
					if ((in_byte == esu8_pkg::CH_BACKSLASH) && !end_of_text) begin
						nxt.mode = esu8_pkg::MODE_ESC;
					end else begin
						tail_en = 1'b1;
					end
				end
			end
		endcase
		if (end_of_text) begin
			nxt      = '0;
			nxt.mode = esu8_pkg::MODE_PLAIN;
		end
	end

	// Assemble the encoded run bytes followed by the pass-through byte.
	always_comb begin
		enc     = esu8_pkg::utf8_encode(run_v, run_ovf);
		run_len = run_en ? enc.len : '0;
		bundle  = '0;
		for (int i = 0; i < esu8_pkg::MAX_OUT; i++) begin
			if (i < 4 && esu8_pkg::LEN_W'(i) < run_len) begin
				bundle.bytes[i] = enc.bytes[i[1:0]];
				bundle.big[i]   = enc.big;
			end else begin
				bundle.bytes[i] = tail_b;
				bundle.big[i]   = 1'b0;
			end
		end
		bundle.len  = run_len + esu8_pkg::LEN_W'(tail_en);
		bundle.done = end_of_text;
	end

endmodule
`default_nettype wire
